### rtl/pps_pkg.sv
// Shared types, phase codes, command codes and register indexes of the parking sequencer.
package pps_pkg;

    // Field widths
    localparam int DIST_W  = 14;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int CMD_W   = 3;
    localparam int PHASE_W = 4;
    localparam int CNT_W   = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SEEK     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_PASS     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_GAP      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_POS      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TURN1    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_STRAIGHT = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TURN2    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CORRECT  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_DONE     = 4'd9;

    // Motor command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FWD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DBL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DBR   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NUDGE = 3'd6;

    // Word kind on the input channel
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_STOP  = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRONT_MIN      = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLOT_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOT_MIN_TIME  = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TIME    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TURN_ONE_TIME  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STRAIGHT_TIME  = 3'd5;
    localparam logic [IDX_W-1:0] REG_TURN_TWO_TIME  = 3'd6;
    localparam logic [IDX_W-1:0] REG_CORRECT_TIME   = 3'd7;

    // Register reset values
    localparam logic [DIST_W-1:0] RST_FRONT_MIN      = 14'd150;
    localparam logic [DIST_W-1:0] RST_SLOT_THRESHOLD = 14'd250;
    localparam logic [DUR_W-1:0]  RST_SLOT_MIN_TIME  = 16'd800;
    localparam logic [DUR_W-1:0]  RST_OFFSET_TIME    = 16'd350;
    localparam logic [DUR_W-1:0]  RST_TURN_ONE_TIME  = 16'd900;
    localparam logic [DUR_W-1:0]  RST_STRAIGHT_TIME  = 16'd1000;
    localparam logic [DUR_W-1:0]  RST_TURN_TWO_TIME  = 16'd900;
    localparam logic [DUR_W-1:0]  RST_CORRECT_TIME   = 16'd1000;

    // Distance limits
    localparam logic [DIST_W-1:0] NO_ECHO_MAX = 14'd10;
    localparam logic [DIST_W-1:0] FAR_READING = 14'd9990;
    localparam logic [DIST_W-1:0] NUDGE_LOW   = 14'd150;
    localparam logic [DIST_W-1:0] NUDGE_HIGH  = 14'd200;
    localparam logic [CNT_W-1:0]  CONFIRM_FRAMES = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] front_min;
        logic [DIST_W-1:0] slot_threshold;
        logic [DUR_W-1:0]  slot_min_time;
        logic [DUR_W-1:0]  offset_time;
        logic [DUR_W-1:0]  turn_one_time;
        logic [DUR_W-1:0]  straight_time;
        logic [DUR_W-1:0]  turn_two_time;
        logic [DUR_W-1:0]  correct_time;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               armed;
        logic               side_left;
        logic [TIME_W-1:0]  gap_start;
        logic [TIME_W-1:0]  phase_start;
        logic [CNT_W-1:0]   gap_count;
        logic [CNT_W-1:0]   wall_count;
    } t_state;

    typedef struct packed {
        logic               emergency;
        logic               spot_on_left;
        logic [PHASE_W-1:0] phase;
        logic [CMD_W-1:0]   motor_cmd;
    } t_result;

endpackage

### rtl/pps_cfg.sv
// Configuration register file of the parking sequencer.
module pps_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [pps_pkg::IDX_W-1:0] i_wr_index,
    input  logic [pps_pkg::CFG_W-1:0] i_wr_data,
    output pps_pkg::t_cfg             o_cfg
);

    pps_pkg::t_cfg r_cfg;

    // One register written per accepted word; distances keep the low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_min      <= pps_pkg::RST_FRONT_MIN;
            r_cfg.slot_threshold <= pps_pkg::RST_SLOT_THRESHOLD;
            r_cfg.slot_min_time  <= pps_pkg::RST_SLOT_MIN_TIME;
            r_cfg.offset_time    <= pps_pkg::RST_OFFSET_TIME;
            r_cfg.turn_one_time  <= pps_pkg::RST_TURN_ONE_TIME;
            r_cfg.straight_time  <= pps_pkg::RST_STRAIGHT_TIME;
            r_cfg.turn_two_time  <= pps_pkg::RST_TURN_TWO_TIME;
            r_cfg.correct_time   <= pps_pkg::RST_CORRECT_TIME;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                pps_pkg::REG_FRONT_MIN:
                    r_cfg.front_min <= i_wr_data[pps_pkg::DIST_W-1:0];
                pps_pkg::REG_SLOT_THRESHOLD:
                    r_cfg.slot_threshold <= i_wr_data[pps_pkg::DIST_W-1:0];
                pps_pkg::REG_SLOT_MIN_TIME: r_cfg.slot_min_time <= i_wr_data;
                pps_pkg::REG_OFFSET_TIME:   r_cfg.offset_time   <= i_wr_data;
                pps_pkg::REG_TURN_ONE_TIME: r_cfg.turn_one_time <= i_wr_data;
                pps_pkg::REG_STRAIGHT_TIME: r_cfg.straight_time <= i_wr_data;
                pps_pkg::REG_TURN_TWO_TIME: r_cfg.turn_two_time <= i_wr_data;
                pps_pkg::REG_CORRECT_TIME:  r_cfg.correct_time  <= i_wr_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/pps_step.sv
// Next-state and motor command logic for one word of the parking sequencer.
module pps_step (
    input  logic                       i_func,
    input  logic [pps_pkg::DIST_W-1:0] i_front,
    input  logic [pps_pkg::DIST_W-1:0] i_left,
    input  logic [pps_pkg::DIST_W-1:0] i_right,
    input  logic [pps_pkg::TIME_W-1:0] i_now,
    input  pps_pkg::t_cfg              i_cfg,
    input  pps_pkg::t_state            i_state,
    output pps_pkg::t_state            o_state,
    output pps_pkg::t_result           o_result
);

    pps_pkg::t_state             armed_st;
    logic [pps_pkg::DIST_W-1:0]  watch;
    logic [pps_pkg::TIME_W-1:0]  start;
    logic [pps_pkg::DUR_W-1:0]   dur;
    logic [pps_pkg::TIME_W-1:0]  since;
    logic                        time_up;
    logic                        abort;
    logic                        gap_seen;
    logic                        wall_seen;
    logic                        left_wall;
    logic                        right_wall;
    logic                        nudge;
    logic [pps_pkg::CNT_W-1:0]   gap_inc;
    logic [pps_pkg::CNT_W-1:0]   wall_inc;

    // The first frame after a stop arms the sequence and starts wall seeking.
    always_comb begin
        armed_st = i_state;
        if (!i_state.armed) begin
            armed_st.armed       = 1'b1;
            armed_st.phase       = pps_pkg::PH_SEEK;
            armed_st.gap_count   = '0;
            armed_st.wall_count  = '0;
            armed_st.gap_start   = '0;
            armed_st.phase_start = i_now;
        end
    end

    // Sensor decisions on the watched side and the front sensor.
    assign watch      = armed_st.side_left ? i_right : i_left;
    assign abort      = (i_front < i_cfg.front_min) && (i_front > pps_pkg::NO_ECHO_MAX);
    assign gap_seen   = (watch > i_cfg.slot_threshold) || (watch == '0)
                     || (watch >= pps_pkg::FAR_READING);
    assign wall_seen  = (watch <= i_cfg.slot_threshold) && (watch > pps_pkg::NO_ECHO_MAX);
    assign left_wall  = (i_left < i_cfg.slot_threshold) && (i_left > pps_pkg::NO_ECHO_MAX);
    assign right_wall = (i_right < i_cfg.slot_threshold) && (i_right > pps_pkg::NO_ECHO_MAX);
    assign nudge      = (i_front > pps_pkg::NUDGE_LOW) && (i_front < pps_pkg::NUDGE_HIGH);
    assign gap_inc    = armed_st.gap_count + 2'd1;
    assign wall_inc   = armed_st.wall_count + 2'd1;

    // One shared timer compare: gap timing uses the gap start, the rest the phase start.
    always_comb begin
        start = armed_st.phase_start;
        dur   = i_cfg.offset_time;
        unique case (armed_st.phase)
            pps_pkg::PH_GAP: begin
                start = armed_st.gap_start;
                dur   = i_cfg.slot_min_time;
            end
            pps_pkg::PH_TURN1:    dur = i_cfg.turn_one_time;
            pps_pkg::PH_STRAIGHT: dur = i_cfg.straight_time;
            pps_pkg::PH_TURN2:    dur = i_cfg.turn_two_time;
            pps_pkg::PH_CORRECT:  dur = i_cfg.correct_time;
            default:              dur = i_cfg.offset_time;
        endcase
    end

    assign since   = i_now - start;
    assign time_up = since >= {{(pps_pkg::TIME_W-pps_pkg::DUR_W){1'b0}}, dur};

    // Phase sequencing and command selection.
    always_comb begin
        o_state            = i_state;
        o_result.motor_cmd = pps_pkg::CMD_STOP;
        o_result.emergency = 1'b0;
        priority if (i_func == pps_pkg::FUNC_STOP) begin
            o_state.armed = 1'b0;
            o_state.phase = pps_pkg::PH_IDLE;
        end else if (i_state.phase == pps_pkg::PH_DONE) begin
            o_result.motor_cmd = pps_pkg::CMD_STOP;
        end else begin
            o_state = armed_st;
            if (abort) begin
                o_result.emergency = 1'b1;
            end else begin
                unique case (armed_st.phase)
                    pps_pkg::PH_SEEK: begin
                        o_result.motor_cmd = pps_pkg::CMD_FWD;
                        if (left_wall) begin
                            o_state.side_left = 1'b0;
                            o_state.phase     = pps_pkg::PH_PASS;
                        end else if (right_wall) begin
                            o_state.side_left = 1'b1;
                            o_state.phase     = pps_pkg::PH_PASS;
                        end
                    end
                    pps_pkg::PH_PASS: begin
                        o_result.motor_cmd = pps_pkg::CMD_FWD;
                        if (gap_seen) begin
                            o_state.gap_count = gap_inc;
                            if (gap_inc >= pps_pkg::CONFIRM_FRAMES) begin
                                o_state.gap_start  = i_now;
                                o_state.gap_count  = '0;
                                o_state.wall_count = '0;
                                o_state.phase      = pps_pkg::PH_GAP;
                            end
                        end else begin
                            o_state.gap_count = '0;
                        end
                    end
                    pps_pkg::PH_GAP: begin
                        o_result.motor_cmd = pps_pkg::CMD_FWD;
                        if (time_up) begin
                            o_result.motor_cmd  = pps_pkg::CMD_STOP;
                            o_state.phase_start = i_now;
                            o_state.phase       = pps_pkg::PH_POS;
                        end else if (wall_seen) begin
                            o_state.wall_count = wall_inc;
                            if (wall_inc >= pps_pkg::CONFIRM_FRAMES) begin
                                o_state.wall_count = '0;
                                o_state.gap_count  = '0;
                                o_state.phase      = pps_pkg::PH_PASS;
                            end
                        end else begin
                            o_state.wall_count = '0;
                        end
                    end
                    pps_pkg::PH_POS: begin
                        o_result.motor_cmd = pps_pkg::CMD_NONE;
                        if (time_up) begin
                            o_result.motor_cmd  = pps_pkg::CMD_STOP;
                            o_state.phase_start = i_now;
                            o_state.phase       = pps_pkg::PH_TURN1;
                        end
                    end
                    pps_pkg::PH_TURN1: begin
                        o_result.motor_cmd = armed_st.side_left ? pps_pkg::CMD_DBL
                                                                : pps_pkg::CMD_DBR;
                        if (time_up) begin
                            o_result.motor_cmd  = pps_pkg::CMD_STOP;
                            o_state.phase_start = i_now;
                            o_state.phase       = pps_pkg::PH_STRAIGHT;
                        end
                    end
                    pps_pkg::PH_STRAIGHT: begin
                        o_result.motor_cmd = pps_pkg::CMD_BACK;
                        if (time_up) begin
                            o_result.motor_cmd  = pps_pkg::CMD_STOP;
                            o_state.phase_start = i_now;
                            o_state.phase       = pps_pkg::PH_TURN2;
                        end
                    end
                    pps_pkg::PH_TURN2: begin
                        o_result.motor_cmd = armed_st.side_left ? pps_pkg::CMD_DBR
                                                                : pps_pkg::CMD_DBL;
                        if (time_up) begin
                            o_result.motor_cmd  = pps_pkg::CMD_STOP;
                            o_state.phase_start = i_now;
                            o_state.phase       = pps_pkg::PH_CORRECT;
                        end
                    end
                    pps_pkg::PH_CORRECT: begin
                        // A nudge frame keeps its nudge even on the last frame.
                        o_result.motor_cmd = nudge ? pps_pkg::CMD_NUDGE : pps_pkg::CMD_NONE;
                        if (time_up) begin
                            if (!nudge) begin
                                o_result.motor_cmd = pps_pkg::CMD_STOP;
                            end
                            o_state.phase = pps_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        o_result.motor_cmd = pps_pkg::CMD_STOP;
                    end
                endcase
            end
        end
        o_result.phase        = o_state.phase;
        o_result.spot_on_left = o_state.side_left;
    end

endmodule

### rtl/parallel_park_sequencer.sv
// Top level of the parallel parking sequencer: input register, step logic, result register.
//
//  Channel  | Direction | Signals                               | Word
//  ---------+-----------+---------------------------------------+-----------------------------
//  s_axis   | in        | tvalid, tready, tdata[79:0], tuser[0] | sensor frame or stop request
//  m_axis   | out       | tvalid, tready, tdata[15:0]           | motor command and status
//  cfg      | in        | valid, ready, index[2:0], data[15:0]  | register write
//
// Each word passes through the input register and then the result register, and one
// word is taken per cycle while the result side does not stall.
// The sequencer state updates in the same edge that loads the result register.
// A stalled result holds the input register; the input side stays ready while
// either register can move. Synchronous reset clears state, config and valid flags.
module parallel_park_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [13:0] front_dist, [27:14] left_dist, [41:28] right_dist, [73:42] now_ms, zero pad
    input  logic [pps_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] motor_cmd, [6:3] phase, [7] spot_on_left, [8] emergency, zero pad
    output logic [pps_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pps_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]    i_cfg_data
);

    pps_pkg::t_cfg               cfg;
    pps_pkg::t_state             r_state;
    pps_pkg::t_state             n_state;
    pps_pkg::t_result            n_result;
    logic                        r_in_valid;
    logic                        r_in_func;
    logic [pps_pkg::DIST_W-1:0]  r_in_front;
    logic [pps_pkg::DIST_W-1:0]  r_in_left;
    logic [pps_pkg::DIST_W-1:0]  r_in_right;
    logic [pps_pkg::TIME_W-1:0]  r_in_now;
    logic                        r_out_valid;
    pps_pkg::t_result            r_out;
    logic                        step_go;
    logic                        in_take;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    pps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake control.
    assign step_go       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func  <= s_axis_tuser;
            r_in_front <= s_axis_tdata[13:0];
            r_in_left  <= s_axis_tdata[27:14];
            r_in_right <= s_axis_tdata[41:28];
            r_in_now   <= s_axis_tdata[73:42];
        end
    end

    pps_step u_step (
        .i_func   (r_in_func),
        .i_front  (r_in_front),
        .i_left   (r_in_left),
        .i_right  (r_in_right),
        .i_now    (r_in_now),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= pps_pkg::PH_IDLE;
            r_state.armed       <= 1'b0;
            r_state.side_left   <= 1'b0;
            r_state.gap_start   <= '0;
            r_state.phase_start <= '0;
            r_state.gap_count   <= '0;
            r_state.wall_count  <= '0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(pps_pkg::M_DATA_W - $bits(pps_pkg::t_result)){1'b0}}, r_out};

endmodule

### rtl/pps_checker.sv
// Port-level checks of the parking sequencer and their binding to the top level.
module pps_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [pps_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic [pps_pkg::CMD_W-1:0]   cmd;
    logic [pps_pkg::PHASE_W-1:0] phase;
    logic                        emerg;

    assign cmd   = m_axis_tdata[2:0];
    assign phase = m_axis_tdata[6:3];
    assign emerg = m_axis_tdata[8];

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word offered after reset");

    // An abort always stops the motors.
    a_emerg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && emerg |-> cmd == pps_pkg::CMD_STOP)
        else $error("abort without stop command");

    // Only a stop request returns to idle, and it answers with stop.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && phase == pps_pkg::PH_IDLE |-> cmd == pps_pkg::CMD_STOP && !emerg)
        else $error("idle phase with a motion command");

    // Phases stay within the sequence.
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> phase <= pps_pkg::PH_DONE)
        else $error("phase out of range");

endmodule

bind parallel_park_sequencer pps_checker u_pps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/parallel_park_sequencer_test.sv
// Self-checking testbench of the parallel parking sequencer with a predicting scoreboard.
`timescale 1ns / 1ps

module parallel_park_sequencer_test;
    import pps_pkg::*;

    localparam int DIST_MAX    = (1 << DIST_W) - 1;
    localparam int CYCLE_LIMIT = 200000;

    // One sensor frame or stop request as it travels on the input channel
    typedef struct {
        logic              func;
        logic [DIST_W-1:0] front;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] right;
        logic [TIME_W-1:0] now;
    } t_sensor_word;

    // Tracks the sequencer state, predicts the motor word of each frame and checks results.
    class t_park_scoreboard;
        logic [DIST_W-1:0]  front_min;
        logic [DIST_W-1:0]  slot_threshold;
        logic [DUR_W-1:0]   slot_min_time;
        logic [DUR_W-1:0]   offset_time;
        logic [DUR_W-1:0]   turn_one_time;
        logic [DUR_W-1:0]   straight_time;
        logic [DUR_W-1:0]   turn_two_time;
        logic [DUR_W-1:0]   correct_time;
        logic [PHASE_W-1:0] phase_q;
        bit                 armed;
        bit                 side_left;
        logic [TIME_W-1:0]  gap_start;
        logic [TIME_W-1:0]  phase_start;
        logic [CNT_W-1:0]   gap_count;
        logic [CNT_W-1:0]   wall_count;
        t_result            expected_words[$];
        int                 errors;

        function new();
            front_min      = RST_FRONT_MIN;
            slot_threshold = RST_SLOT_THRESHOLD;
            slot_min_time  = RST_SLOT_MIN_TIME;
            offset_time    = RST_OFFSET_TIME;
            turn_one_time  = RST_TURN_ONE_TIME;
            straight_time  = RST_STRAIGHT_TIME;
            turn_two_time  = RST_TURN_TWO_TIME;
            correct_time   = RST_CORRECT_TIME;
            phase_q        = PH_IDLE;
            armed          = 1'b0;
            side_left      = 1'b0;
            gap_start      = '0;
            phase_start    = '0;
            gap_count      = '0;
            wall_count     = '0;
            errors         = 0;
        endfunction

        function void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FRONT_MIN:      front_min = value[DIST_W-1:0];
                REG_SLOT_THRESHOLD: slot_threshold = value[DIST_W-1:0];
                REG_SLOT_MIN_TIME:  slot_min_time = value;
                REG_OFFSET_TIME:    offset_time = value;
                REG_TURN_ONE_TIME:  turn_one_time = value;
                REG_STRAIGHT_TIME:  straight_time = value;
                REG_TURN_TWO_TIME:  turn_two_time = value;
                REG_CORRECT_TIME:   correct_time = value;
                default: ;
            endcase
        endfunction

        // Elapsed time is an unsigned 32-bit difference, so it wraps.
        function bit time_up(logic [TIME_W-1:0] now, logic [TIME_W-1:0] start,
                             logic [DUR_W-1:0] span);
            logic [TIME_W-1:0] passed;
            passed = now - start;
            return passed >= {{(TIME_W-DUR_W){1'b0}}, span};
        endfunction

        function void enter_phase(logic [TIME_W-1:0] now, logic [PHASE_W-1:0] next);
            phase_start = now;
            phase_q = next;
        endfunction

        // Steps the sequencer on an accepted word and queues the motor word it must give.
        function void note_word(t_sensor_word w);
            t_result           want;
            logic [DIST_W-1:0] watch;
            logic [CMD_W-1:0]  cmd;
            logic              emerg;
            cmd = CMD_STOP;
            emerg = 1'b0;
            if (w.func == FUNC_STOP) begin
                armed = 1'b0;
                phase_q = PH_IDLE;
            end else if (phase_q != PH_DONE) begin
                // The first frame after a stop arms the sequence.
                if (!armed) begin
                    armed = 1'b1;
                    phase_q = PH_SEEK;
                    gap_count = '0;
                    wall_count = '0;
                    gap_start = '0;
                    phase_start = w.now;
                end
                if (w.front < front_min && w.front > NO_ECHO_MAX) begin
                    emerg = 1'b1;
                end else begin
                    watch = side_left ? w.right : w.left;
                    case (phase_q)
                        PH_SEEK: begin
                            cmd = CMD_FWD;
                            if (w.left < slot_threshold && w.left > NO_ECHO_MAX) begin
                                side_left = 1'b0;
                                phase_q = PH_PASS;
                            end else if (w.right < slot_threshold && w.right > NO_ECHO_MAX) begin
                                side_left = 1'b1;
                                phase_q = PH_PASS;
                            end
                        end
                        PH_PASS: begin
                            cmd = CMD_FWD;
                            if (watch > slot_threshold || watch == 0 || watch >= FAR_READING) begin
                                gap_count = gap_count + 1'b1;
                                if (gap_count >= CONFIRM_FRAMES) begin
                                    gap_start = w.now;
                                    gap_count = '0;
                                    wall_count = '0;
                                    phase_q = PH_GAP;
                                end
                            end else begin
                                gap_count = '0;
                            end
                        end
                        PH_GAP: begin
                            cmd = CMD_FWD;
                            if (time_up(w.now, gap_start, slot_min_time)) begin
                                cmd = CMD_STOP;
                                enter_phase(w.now, PH_POS);
                            end else if (watch <= slot_threshold && watch > NO_ECHO_MAX) begin
                                // Three wall readings in a row reject the gap.
                                wall_count = wall_count + 1'b1;
                                if (wall_count >= CONFIRM_FRAMES) begin
                                    wall_count = '0;
                                    gap_count = '0;
                                    phase_q = PH_PASS;
                                end
                            end else begin
                                wall_count = '0;
                            end
                        end
                        PH_POS: begin
                            cmd = CMD_NONE;
                            if (time_up(w.now, phase_start, offset_time)) begin
                                cmd = CMD_STOP;
                                enter_phase(w.now, PH_TURN1);
                            end
                        end
                        PH_TURN1: begin
                            cmd = side_left ? CMD_DBL : CMD_DBR;
                            if (time_up(w.now, phase_start, turn_one_time)) begin
                                cmd = CMD_STOP;
                                enter_phase(w.now, PH_STRAIGHT);
                            end
                        end
                        PH_STRAIGHT: begin
                            cmd = CMD_BACK;
                            if (time_up(w.now, phase_start, straight_time)) begin
                                cmd = CMD_STOP;
                                enter_phase(w.now, PH_TURN2);
                            end
                        end
                        PH_TURN2: begin
                            cmd = side_left ? CMD_DBR : CMD_DBL;
                            if (time_up(w.now, phase_start, turn_two_time)) begin
                                cmd = CMD_STOP;
                                enter_phase(w.now, PH_CORRECT);
                            end
                        end
                        PH_CORRECT: begin
                            cmd = (w.front > NUDGE_LOW && w.front < NUDGE_HIGH) ?
                                  CMD_NUDGE : CMD_NONE;
                            if (time_up(w.now, phase_start, correct_time)) begin
                                if (cmd == CMD_NONE)
                                    cmd = CMD_STOP;
                                phase_q = PH_DONE;
                            end
                        end
                        default: cmd = CMD_STOP;
                    endcase
                end
            end
            want.motor_cmd = cmd;
            want.phase = phase_q;
            want.spot_on_left = side_left;
            want.emergency = emerg;
            expected_words.push_back(want);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [M_DATA_W-1:0] data);
            t_result got;
            t_result want;
            got = data[$bits(t_result)-1:0];
            if (expected_words.size() == 0) begin
                $error("motor word 0x%h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("motor_cmd", want.motor_cmd, got.motor_cmd);
            compare_field("phase", want.phase, got.phase);
            compare_field("spot_on_left", want.spot_on_left, got.spot_on_left);
            compare_field("emergency", want.emergency, got.emergency);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    t_park_scoreboard      sb;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    rx_hold = 1'b0;
    int                    cycle_count = 0;
    logic [TIME_W-1:0]     sensor_time = '0;
    t_sensor_word          directed_words[$];

    parallel_park_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The result side stalls at random, or for a whole hold-off stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Every handshake is seen at the rising edge.
    always @(posedge i_clk) begin
        t_sensor_word w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                w.func  = s_axis_tuser;
                w.front = s_axis_tdata[DIST_W-1:0];
                w.left  = s_axis_tdata[2*DIST_W-1:DIST_W];
                w.right = s_axis_tdata[3*DIST_W-1:2*DIST_W];
                w.now   = s_axis_tdata[3*DIST_W+TIME_W-1:3*DIST_W];
                sb.note_word(w);
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                sb.apply_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Called at a falling edge; returns at the edge that takes the word.
    task automatic send_word(input t_sensor_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_DATA_W-3*DIST_W-TIME_W){1'b0}}, w.now, w.right, w.left, w.front};
        s_axis_tuser <= w.func;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops offering words and waits until every motor word has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] fmin, input logic [CFG_W-1:0] thr,
                                input logic [CFG_W-1:0] slot, input logic [CFG_W-1:0] offs,
                                input logic [CFG_W-1:0] turn1, input logic [CFG_W-1:0] str,
                                input logic [CFG_W-1:0] turn2, input logic [CFG_W-1:0] corr);
        write_reg(REG_FRONT_MIN, fmin);
        write_reg(REG_SLOT_THRESHOLD, thr);
        write_reg(REG_SLOT_MIN_TIME, slot);
        write_reg(REG_OFFSET_TIME, offs);
        write_reg(REG_TURN_ONE_TIME, turn1);
        write_reg(REG_STRAIGHT_TIME, str);
        write_reg(REG_TURN_TWO_TIME, turn2);
        write_reg(REG_CORRECT_TIME, corr);
    endtask

    function automatic void add_word(logic func, int front, int left, int right,
                                     logic [TIME_W-1:0] now);
        t_sensor_word w;
        w.func  = func;
        w.front = DIST_W'(front);
        w.left  = DIST_W'(left);
        w.right = DIST_W'(right);
        w.now   = now;
        directed_words.push_back(w);
    endfunction

    // A front reading that does not trip the obstacle abort.
    function automatic logic [DIST_W-1:0] clear_front();
        if ($urandom_range(3) == 0)
            return DIST_W'($urandom_range(NO_ECHO_MAX));
        return DIST_W'($urandom_range(DIST_MAX, sb.front_min));
    endfunction

    // A side reading strictly inside the wall band, as the wall search needs.
    function automatic logic [DIST_W-1:0] seek_wall();
        if (sb.slot_threshold > NO_ECHO_MAX + 1)
            return DIST_W'($urandom_range(sb.slot_threshold - 1, NO_ECHO_MAX + 1));
        return DIST_W'($urandom_range(DIST_MAX));
    endfunction

    // A watched-side reading: gap with the given chance, else mostly wall, else no echo.
    function automatic logic [DIST_W-1:0] side_reading(int gap_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < gap_pct) begin
            case ($urandom_range(2))
                0: return '0;
                1: return DIST_W'($urandom_range(DIST_MAX, FAR_READING));
                default: return (sb.slot_threshold < DIST_MAX) ?
                                DIST_W'($urandom_range(DIST_MAX, sb.slot_threshold + 1)) : '0;
            endcase
        end
        if (pick < gap_pct + (100 - gap_pct) * 4 / 5 && sb.slot_threshold > NO_ECHO_MAX)
            return DIST_W'($urandom_range(sb.slot_threshold, NO_ECHO_MAX + 1));
        return DIST_W'($urandom_range(NO_ECHO_MAX, 1));
    endfunction

    // Builds a frame that mostly moves the sequence on from where it stands now.
    task automatic next_word(output t_sensor_word w);
        int                roll;
        bit                timed;
        logic [DUR_W-1:0]  span;
        logic [TIME_W-1:0] start;
        logic [DIST_W-1:0] watch;
        timed = 1'b0;
        span = '0;
        start = '0;
        w.func = FUNC_FRAME;
        w.front = clear_front();
        w.left = DIST_W'($urandom_range(DIST_MAX));
        w.right = DIST_W'($urandom_range(DIST_MAX));
        sensor_time = sensor_time + $urandom_range(40);
        roll = $urandom_range(99);
        if (roll < 8) begin
            // Noise: anything at all, stop requests and time jumps included.
            w.func = ($urandom_range(3) == 0) ? FUNC_STOP : FUNC_FRAME;
            w.front = DIST_W'($urandom_range(DIST_MAX));
            if ($urandom_range(1))
                sensor_time = $urandom;
        end else begin
            watch = side_reading(55);
            case (sb.phase_q)
                PH_IDLE, PH_SEEK: begin
                    if ($urandom_range(99) < 70) begin
                        if ($urandom_range(1))
                            w.left = seek_wall();
                        else
                            w.right = seek_wall();
                    end
                end
                PH_PASS: begin
                    watch = side_reading(75);
                    if (sb.side_left) w.right = watch; else w.left = watch;
                end
                PH_GAP: begin
                    if (sb.side_left) w.right = watch; else w.left = watch;
                    timed = 1'b1;
                    span = sb.slot_min_time;
                    start = sb.gap_start;
                end
                PH_POS: begin
                    timed = 1'b1;
                    span = sb.offset_time;
                    start = sb.phase_start;
                end
                PH_TURN1: begin
                    timed = 1'b1;
                    span = sb.turn_one_time;
                    start = sb.phase_start;
                end
                PH_STRAIGHT: begin
                    timed = 1'b1;
                    span = sb.straight_time;
                    start = sb.phase_start;
                end
                PH_TURN2: begin
                    timed = 1'b1;
                    span = sb.turn_two_time;
                    start = sb.phase_start;
                end
                PH_CORRECT: begin
                    timed = 1'b1;
                    span = sb.correct_time;
                    start = sb.phase_start;
                    if ($urandom_range(1))
                        w.front = DIST_W'($urandom_range(NUDGE_HIGH - 1, NUDGE_LOW + 1));
                end
                PH_DONE: begin
                    if ($urandom_range(99) < 60)
                        w.func = FUNC_STOP;
                end
                default: ;
            endcase
            // Timed phases hit the end exactly, just miss it, or creep toward it.
            if (timed) begin
                roll = $urandom_range(99);
                if (roll < 15)
                    sensor_time = start + span;
                else if (roll < 25 && span != 0)
                    sensor_time = start + span - 1;
                else
                    sensor_time = sensor_time + $urandom_range(span / 4 + 2);
            end
            if ($urandom_range(99) < 5 && sb.front_min > NO_ECHO_MAX + 1)
                w.front = DIST_W'($urandom_range(sb.front_min - 1, NO_ECHO_MAX + 1));
        end
        w.now = sensor_time;
    endtask

    task automatic run_random(input int count);
        t_sensor_word w;
        repeat (count) begin
            @(negedge i_clk);
            next_word(w);
            send_word(w);
        end
    endtask

    initial begin
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] tg;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through a whole parking run with the reset settings.
        // Time starts just below the 32-bit wrap so the gap timing crosses it.
        send_idle_pct = 17;
        recv_idle_pct = 60;
        t = 32'hFFFF_FD00;
        add_word(FUNC_FRAME, 0, 0, 0, t);              // arms, no wall in sight
        t += 10; add_word(FUNC_FRAME, 11, 200, 0, t);  // lowest front abort
        t += 10; add_word(FUNC_FRAME, 10, 10, 11, t);  // no echo ahead, wall on the right
        t += 10; add_word(FUNC_FRAME, 150, 0, DIST_MAX, t);
        t += 10; add_word(FUNC_FRAME, DIST_MAX, DIST_MAX, 100, t);  // wall clears gap count
        t += 10; add_word(FUNC_FRAME, 0, 0, 0, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 9990, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 251, t);   // gap confirmed
        t += 10; add_word(FUNC_FRAME, 0, 0, 250, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 5, t);     // neither wall nor gap
        t += 10; add_word(FUNC_FRAME, 0, 0, 250, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 11, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 200, t);   // gap rejected
        t += 10; add_word(FUNC_FRAME, 0, 0, 0, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, DIST_MAX, t);
        t += 10; add_word(FUNC_FRAME, 0, 0, 0, t);
        tg = t;
        add_word(FUNC_FRAME, 0, 0, DIST_MAX, tg + 799);  // one short of the slot time
        t = tg + 800; add_word(FUNC_FRAME, 0, 0, DIST_MAX, t);
        add_word(FUNC_FRAME, 0, 0, 0, t + 349);
        t += 350; add_word(FUNC_FRAME, 0, 0, 0, t);
        add_word(FUNC_FRAME, 0, 0, 0, t + 1);
        t += 900; add_word(FUNC_FRAME, 0, 0, 0, t);
        t += 1000; add_word(FUNC_FRAME, 0, 0, 0, t);
        t += 900; add_word(FUNC_FRAME, 0, 0, 0, t);
        add_word(FUNC_FRAME, 175, 0, 0, t + 1);         // nudge while correcting
        t += 1000; add_word(FUNC_FRAME, 0, 0, 0, t);     // done
        add_word(FUNC_FRAME, 0, 200, 0, t + 5);          // frames in done only stop
        add_word(FUNC_STOP, DIST_MAX, DIST_MAX, DIST_MAX, 32'hFFFF_FFFF);
        add_word(FUNC_FRAME, DIST_MAX, 200, 0, 32'h0000_0000);
        foreach (directed_words[i]) begin
            @(negedge i_clk);
            send_word(directed_words[i]);
        end
        drain();

        // Mid-range settings, upper bits of the short registers set at random
        program_regs(CFG_W'($urandom_range(400, 100) | ($urandom_range(3) << DIST_W)),
                     CFG_W'($urandom_range(600, 150) | ($urandom_range(3) << DIST_W)),
                     CFG_W'($urandom_range(2000, 50)), CFG_W'($urandom_range(2000, 50)),
                     CFG_W'($urandom_range(2000, 50)), CFG_W'($urandom_range(2000, 50)),
                     CFG_W'($urandom_range(2000, 50)), CFG_W'($urandom_range(2000, 50)));
        sensor_time = $urandom;
        run_random(500);
        drain();

        // Extremes: no abort possible, widest wall band, every phase ends at once
        send_idle_pct = 60;
        recv_idle_pct = 17;
        program_regs(16'hC000, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(350);
        drain();

        // Extremes: nearly every front reading aborts, no wall, longest phases
        program_regs(16'h3FFF, 16'h0000, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(200);
        drain();

        // No idling; the result side holds off long enough to fill the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(16'd160, 16'd300, CFG_W'($urandom_range(3000)),
                     CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(3000)),
                     CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(3000)),
                     CFG_W'($urandom_range(3000)));
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        run_random(400);
        drain();
        run_random(420);
        drain();

        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
